// ===== hw/rtl/b64e_pkg.sv =====
// Package for the Base64 stream encoder.
// Holds the payload structs, group phase codes, job record and alphabet lookup.
// No dependencies.
package b64e_pkg;

  // Input beat: one raw message byte and its end-of-message flag
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } b64e_in_t;

  // Output beat: one ASCII character and its end-of-message flag
  typedef struct packed {
    logic [6:0] char_code;
    logic       last_char;
  } b64e_out_t;

  // Position within the three-byte group
  typedef enum logic [1:0] {
    PhStart = 2'd0,
    PhOne   = 2'd1,
    PhTwo   = 2'd2
  } b64e_phase_e;

  // Characters one input byte produces (one to four)
  localparam int unsigned MaxChars = 4;
  localparam int unsigned CharIdxW = $clog2(MaxChars);

  // Depth of the job queue between front and back
  localparam int unsigned JobDepth = 4;
  localparam int unsigned JobPtrW  = $clog2(JobDepth);
  localparam int unsigned JobCntW  = JobPtrW + 1;

  localparam logic [6:0] PadChar = 7'd61;  // '='

  // One job: the characters of one byte, the index of the final one, end flag
  typedef struct packed {
    logic [MaxChars-1:0][6:0] chars;
    logic [CharIdxW-1:0]      n_last;
    logic                     last;
  } b64e_job_t;

  // Standard alphabet, first character in the top byte
  localparam logic [511:0] Alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  // Map a 6-bit group to its ASCII character
  function automatic logic [6:0] enc6(input logic [5:0] v);
    logic [8:0] base;
    base = {~v, 3'b000};
    return Alphabet[base +: 7];
  endfunction

endpackage

// ===== hw/rtl/b64e_front.sv =====
// Front end of the Base64 encoder: accepts bytes and builds character jobs.
// Keeps group phase and leftover bits. Depends on b64e_pkg.
module b64e_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  b64e_pkg::b64e_in_t  in_i,
  input  logic                job_full_i,
  output logic                job_wr_o,
  output b64e_pkg::b64e_job_t job_o
);
  import b64e_pkg::*;

  b64e_phase_e phase_q, phase_d;
  logic [3:0]  lo_q, lo_d;
  logic        fin;
  logic [7:0]  b;

  assign full     = job_full_i;
  assign job_wr_o = push && !job_full_i;
  assign b        = in_i.data_byte;
  assign fin      = in_i.last_byte;

  // Classify the byte by group phase and build its characters
  always_comb begin
    job_o.chars  = {MaxChars{PadChar}};
    job_o.n_last = '0;
    job_o.last   = fin;
    phase_d      = phase_q;
    lo_d         = lo_q;
    unique case (phase_q)
      PhOne: begin
        job_o.chars[0] = enc6({lo_q[1:0], b[7:4]});
        lo_d    = b[3:0];
        phase_d = PhTwo;
        if (fin) begin
          job_o.chars[1] = enc6({b[3:0], 2'b00});
          job_o.n_last   = CharIdxW'(2);
        end
      end
      PhTwo: begin
        job_o.chars[0] = enc6({lo_q, b[7:6]});
        job_o.chars[1] = enc6(b[5:0]);
        job_o.n_last   = CharIdxW'(1);
        lo_d    = '0;
        phase_d = PhStart;
      end
      default: begin
        // start of group; the unused phase code behaves the same
        job_o.chars[0] = enc6(b[7:2]);
        lo_d    = {2'b00, b[1:0]};
        phase_d = PhOne;
        if (fin) begin
          job_o.chars[1] = enc6({b[1:0], 4'b0000});
          job_o.n_last   = CharIdxW'(3);
        end
      end
    endcase
    if (fin) begin
      phase_d = PhStart;
      lo_d    = '0;
    end
  end

  // Group state, advanced on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhStart;
      lo_q    <= '0;
    end else if (job_wr_o) begin
      phase_q <= phase_d;
      lo_q    <= lo_d;
    end
  end

endmodule

// ===== hw/rtl/b64e_job_fifo.sv =====
// Short job queue between the encoder front and back ends.
// Small register array with read and write pointers. Depends on b64e_pkg.
module b64e_job_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_i,
  input  b64e_pkg::b64e_job_t wdata_i,
  output logic                full_o,
  input  logic                rd_i,
  output b64e_pkg::b64e_job_t rdata_o,
  output logic                empty_o
);
  import b64e_pkg::*;

  b64e_job_t          mem_q [JobDepth];
  logic [JobPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [JobPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [JobCntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == JobCntW'(JobDepth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_i) begin
      wr_ptr_d = (wr_ptr_q == JobPtrW'(JobDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_i) begin
      rd_ptr_d = (rd_ptr_q == JobPtrW'(JobDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_i && !rd_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_i && !wr_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  // Checks
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_i && full_o))
    else $error("job queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rd_i && empty_o))
    else $error("job queue read while empty");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= JobCntW'(JobDepth))
    else $error("job queue count beyond depth");

endmodule

// ===== hw/rtl/b64e_back.sv =====
// Back end of the Base64 encoder: serialises queued jobs one character per cycle
// while the output is popped or empty. Owns the output register. Depends on b64e_pkg.
module b64e_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  b64e_pkg::b64e_job_t job_i,
  input  logic                job_empty_i,
  output logic                job_rd_o,
  output logic                empty,
  input  logic                pop,
  output b64e_pkg::b64e_out_t out_o
);
  import b64e_pkg::*;

  logic [CharIdxW-1:0] idx_q, idx_d;
  logic                out_vld_q, out_vld_d;
  b64e_out_t           out_q, out_d;
  logic                load;
  logic                at_end;

  assign at_end   = (idx_q == job_i.n_last);
  assign load     = (!out_vld_q || pop) && !job_empty_i;
  assign job_rd_o = load && at_end;
  assign empty    = !out_vld_q;
  assign out_o    = out_q;

  // Next character, index and output valid
  always_comb begin
    idx_d     = idx_q;
    out_d     = out_q;
    out_vld_d = out_vld_q;
    if (pop && out_vld_q) begin
      out_vld_d = 1'b0;
    end
    if (load) begin
      out_d.char_code = job_i.chars[idx_q];
      out_d.last_char = job_i.last && at_end;
      out_vld_d       = 1'b1;
      idx_d           = at_end ? '0 : idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      idx_q     <= idx_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // Checks
  a_idx_in_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !job_empty_i |-> idx_q <= job_i.n_last)
    else $error("character index beyond job length");

  a_idx_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_rd_o |=> idx_q == '0)
    else $error("index not cleared after job retired");

endmodule

// ===== hw/rtl/base64_stream_encoder_unit.sv =====
// Base64 stream encoder: one byte in per beat, one to four characters out.
// A character passes through the job queue and then the output register to out_o.
// One character per cycle leaves the single output register while pop is high and
// a job is queued; bytes enter every cycle while the four-entry job queue has room.
// Reset clears phase, queue and output valid.
// Top level; depends on b64e_pkg, b64e_front, b64e_job_fifo, b64e_back.
module base64_stream_encoder_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  b64e_pkg::b64e_in_t  in_i,
  output logic                empty,
  input  logic                pop,
  output b64e_pkg::b64e_out_t out_o
);
  import b64e_pkg::*;

  b64e_job_t wjob, rjob;
  logic      job_wr, job_rd, job_full, job_empty;

  // Front: accept and classify bytes
  b64e_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_i       (in_i),
    .job_full_i (job_full),
    .job_wr_o   (job_wr),
    .job_o      (wjob)
  );

  // Queue between the two halves
  b64e_job_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (job_wr),
    .wdata_i (wjob),
    .full_o  (job_full),
    .rd_i    (job_rd),
    .rdata_o (rjob),
    .empty_o (job_empty)
  );

  // Back: emit characters
  b64e_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (rjob),
    .job_empty_i (job_empty),
    .job_rd_o    (job_rd),
    .empty       (empty),
    .pop         (pop),
    .out_o       (out_o)
  );

endmodule
